// ===== hdl/ssa_pkg.sv =====
// shared types, geometry constants and codes for the sector allocator
package ssa_pkg;

	localparam int MAX_PLATES       = 4;
	localparam int MAX_SURFACES     = 2;
	localparam int MAX_TRACKS       = 16;
	localparam int MAX_SECTORS      = 32;
	localparam int MAX_SECTOR_BYTES = 4096;

	// field widths of the address and the counts
	localparam int PLATE_W  = 2;
	localparam int SURF_W   = 1;
	localparam int TRACK_W  = 4;
	localparam int SECT_W   = 5;
	localparam int OFFS_W   = 12;
	localparam int LEN_W    = 13;
	localparam int PCNT_W   = 3;
	localparam int SCNT_W   = 2;
	localparam int TCNT_W   = 5;
	localparam int KCNT_W   = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W    = 13;

	localparam int ADDR_W      = PLATE_W + SURF_W + TRACK_W + SECT_W;
	localparam int STORE_DEPTH = MAX_PLATES * MAX_SURFACES * MAX_TRACKS * MAX_SECTORS;

	// command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REWIND = 1'b1;

	// status codes
	localparam logic [1:0] ST_PLACED    = 2'd0;
	localparam logic [1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_REWOUND   = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PLATE_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SURFACE_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRACK_COUNT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SECTOR_COUNT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SECTOR_BYTES  = 3'd4;

	// register reset values
	localparam logic [PCNT_W-1:0] PLATE_COUNT_RST   = 3'd4;
	localparam logic [SCNT_W-1:0] SURFACE_COUNT_RST = 2'd2;
	localparam logic [TCNT_W-1:0] TRACK_COUNT_RST   = 5'd16;
	localparam logic [KCNT_W-1:0] SECTOR_COUNT_RST  = 6'd32;
	localparam logic [LEN_W-1:0]  SECTOR_BYTES_RST  = 13'd512;

	typedef struct packed {
		logic             command;
		logic [LEN_W-1:0] length;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [PLATE_W-1:0] plate;
		logic [SURF_W-1:0]  surface;
		logic [TRACK_W-1:0] track;
		logic [SECT_W-1:0]  sector_index;
		logic [OFFS_W-1:0]  byte_offset;
	} rsp_t;

endpackage

// ===== hdl/ssa_ram.sv =====
// generic single-write single-read ram with registered read data
module ssa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/sequential_sector_allocator_core.sv =====
// next-fit sector allocator: cursor sequencer, used-byte store and result register
// rewind, too-large and full answers: idle goes straight to done, then the result register.
// an insert that fits the cursor's sector passes read, check and done before the result register;
// each sector passed over adds its store read and room check, only the read if outside geometry.
// one request at a time; req_stall is high from accept until the result is loaded.
// after reset the used-byte store is cleared one entry a cycle, 4096 entries, with req_stall high.
module sequential_sector_allocator_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ssa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ssa_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  ssa_pkg::req_t                      req,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output ssa_pkg::rsp_t                      rsp
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	localparam int AW = ssa_pkg::ADDR_W;
	localparam logic [AW-1:0] CLR_LAST = AW'(ssa_pkg::STORE_DEPTH - 1);

	localparam logic [ssa_pkg::PCNT_W-1:0] PC_MAX = ssa_pkg::PCNT_W'(ssa_pkg::MAX_PLATES);
	localparam logic [ssa_pkg::SCNT_W-1:0] SC_MAX = ssa_pkg::SCNT_W'(ssa_pkg::MAX_SURFACES);
	localparam logic [ssa_pkg::TCNT_W-1:0] TC_MAX = ssa_pkg::TCNT_W'(ssa_pkg::MAX_TRACKS);
	localparam logic [ssa_pkg::KCNT_W-1:0] KC_MAX = ssa_pkg::KCNT_W'(ssa_pkg::MAX_SECTORS);
	localparam logic [ssa_pkg::LEN_W-1:0]  CAP_MAX =
		ssa_pkg::LEN_W'(ssa_pkg::MAX_SECTOR_BYTES);

	logic [2:0]                        state_q;
	logic [AW-1:0]                     clr_q;
	logic [ssa_pkg::PCNT_W-1:0]        plate_count_q;
	logic [ssa_pkg::SCNT_W-1:0]        surface_count_q;
	logic [ssa_pkg::TCNT_W-1:0]        track_count_q;
	logic [ssa_pkg::KCNT_W-1:0]        sector_count_q;
	logic [ssa_pkg::LEN_W-1:0]         sector_bytes_q;
	logic [ssa_pkg::PLATE_W-1:0]       cur_plate_q;
	logic [ssa_pkg::SURF_W-1:0]        cur_surface_q;
	logic [ssa_pkg::TRACK_W-1:0]       cur_track_q;
	logic [ssa_pkg::SECT_W-1:0]        cur_sector_q;
	logic                              full_q;
	logic [ssa_pkg::LEN_W-1:0]         len_q;
	ssa_pkg::rsp_t                     res_q;
	ssa_pkg::rsp_t                     rsp_q;
	logic                              rsp_valid_q;

	// saturated geometry
	logic [ssa_pkg::PCNT_W-1:0] pc;
	logic [ssa_pkg::SCNT_W-1:0] sc;
	logic [ssa_pkg::TCNT_W-1:0] tc;
	logic [ssa_pkg::KCNT_W-1:0] kc;
	logic [ssa_pkg::LEN_W-1:0]  cap;

	always_comb begin
		pc  = (plate_count_q == '0) ? ssa_pkg::PCNT_W'(1) :
		      (plate_count_q > PC_MAX) ? PC_MAX : plate_count_q;
		sc  = (surface_count_q == '0) ? ssa_pkg::SCNT_W'(1) :
		      (surface_count_q > SC_MAX) ? SC_MAX : surface_count_q;
		tc  = (track_count_q == '0) ? ssa_pkg::TCNT_W'(1) :
		      (track_count_q > TC_MAX) ? TC_MAX : track_count_q;
		kc  = (sector_count_q == '0) ? ssa_pkg::KCNT_W'(1) :
		      (sector_count_q > KC_MAX) ? KC_MAX : sector_count_q;
		cap = (sector_bytes_q == '0) ? ssa_pkg::LEN_W'(1) :
		      (sector_bytes_q > CAP_MAX) ? CAP_MAX : sector_bytes_q;
	end

	// cursor inside geometry and next cursor position with carries
	logic                         in_geom;
	logic [ssa_pkg::KCNT_W-1:0]   sec_inc;
	logic [ssa_pkg::TCNT_W-1:0]   trk_inc;
	logic [ssa_pkg::SCNT_W-1:0]   srf_inc;
	logic [ssa_pkg::PCNT_W-1:0]   plt_inc;
	logic                         sec_wrap, trk_wrap, srf_wrap, plt_wrap;
	logic                         run_out;
	logic [ssa_pkg::PLATE_W-1:0]  nxt_plate;
	logic [ssa_pkg::SURF_W-1:0]   nxt_surface;
	logic [ssa_pkg::TRACK_W-1:0]  nxt_track;
	logic [ssa_pkg::SECT_W-1:0]   nxt_sector;

	always_comb begin
		in_geom = (ssa_pkg::PCNT_W'(cur_plate_q) < pc) &&
		          (ssa_pkg::SCNT_W'(cur_surface_q) < sc) &&
		          (ssa_pkg::TCNT_W'(cur_track_q) < tc) &&
		          (ssa_pkg::KCNT_W'(cur_sector_q) < kc);
		sec_inc  = ssa_pkg::KCNT_W'(cur_sector_q) + ssa_pkg::KCNT_W'(1);
		trk_inc  = ssa_pkg::TCNT_W'(cur_track_q) + ssa_pkg::TCNT_W'(1);
		srf_inc  = ssa_pkg::SCNT_W'(cur_surface_q) + ssa_pkg::SCNT_W'(1);
		plt_inc  = ssa_pkg::PCNT_W'(cur_plate_q) + ssa_pkg::PCNT_W'(1);
		sec_wrap = sec_inc >= kc;
		trk_wrap = trk_inc >= tc;
		srf_wrap = srf_inc >= sc;
		plt_wrap = plt_inc >= pc;
		run_out  = sec_wrap && trk_wrap && srf_wrap && plt_wrap;
		nxt_plate   = cur_plate_q;
		nxt_surface = cur_surface_q;
		nxt_track   = cur_track_q;
		nxt_sector  = sec_inc[ssa_pkg::SECT_W-1:0];
		if (sec_wrap) begin
			nxt_sector = '0;
			nxt_track  = trk_inc[ssa_pkg::TRACK_W-1:0];
			if (trk_wrap) begin
				nxt_track   = '0;
				nxt_surface = srf_inc[ssa_pkg::SURF_W-1:0];
				if (srf_wrap) begin
					nxt_surface = '0;
					nxt_plate   = plt_inc[ssa_pkg::PLATE_W-1:0];
					if (plt_wrap) begin
						nxt_plate = '0;
					end
				end
			end
		end
	end

	// store access and the room check
	logic [AW-1:0]              cur_addr;
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [ssa_pkg::LEN_W-1:0]  ram_wdata;
	logic                       ram_re;
	logic [ssa_pkg::LEN_W-1:0]  used;
	logic [ssa_pkg::LEN_W-1:0]  room;
	logic                       fits;

	assign cur_addr = {cur_plate_q, cur_surface_q, cur_track_q, cur_sector_q};
	assign room     = (used >= cap) ? '0 : cap - used;
	assign fits     = len_q <= room;
	assign ram_re   = (state_q == S_READ) && in_geom;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_addr;
		ram_wdata = used + len_q;
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == S_CHECK && fits) begin
			ram_we = 1'b1;
		end
	end

	ssa_ram #(
		.WIDTH(ssa_pkg::LEN_W),
		.DEPTH(ssa_pkg::STORE_DEPTH)
	) u_used (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (cur_addr),
		.rdata (used)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plate_count_q   <= ssa_pkg::PLATE_COUNT_RST;
			surface_count_q <= ssa_pkg::SURFACE_COUNT_RST;
			track_count_q   <= ssa_pkg::TRACK_COUNT_RST;
			sector_count_q  <= ssa_pkg::SECTOR_COUNT_RST;
			sector_bytes_q  <= ssa_pkg::SECTOR_BYTES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ssa_pkg::REG_PLATE_COUNT: begin
					plate_count_q <= cfg_data[ssa_pkg::PCNT_W-1:0];
				end
				ssa_pkg::REG_SURFACE_COUNT: begin
					surface_count_q <= cfg_data[ssa_pkg::SCNT_W-1:0];
				end
				ssa_pkg::REG_TRACK_COUNT: begin
					track_count_q <= cfg_data[ssa_pkg::TCNT_W-1:0];
				end
				ssa_pkg::REG_SECTOR_COUNT: begin
					sector_count_q <= cfg_data[ssa_pkg::KCNT_W-1:0];
				end
				ssa_pkg::REG_SECTOR_BYTES: begin
					sector_bytes_q <= cfg_data[ssa_pkg::LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	logic req_take;
	logic rsp_free;

	assign req_take = req_valid && (state_q == S_IDLE);
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			cur_plate_q   <= '0;
			cur_surface_q <= '0;
			cur_track_q   <= '0;
			cur_sector_q  <= '0;
			full_q        <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_take) begin
						if (req.command == ssa_pkg::CMD_REWIND) begin
							cur_plate_q   <= '0;
							cur_surface_q <= '0;
							cur_track_q   <= '0;
							cur_sector_q  <= '0;
							full_q        <= 1'b0;
							state_q       <= S_DONE;
						end else if (req.length > cap || full_q) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					if (in_geom) begin
						state_q <= S_CHECK;
					end else begin
						cur_plate_q   <= nxt_plate;
						cur_surface_q <= nxt_surface;
						cur_track_q   <= nxt_track;
						cur_sector_q  <= nxt_sector;
						if (run_out) begin
							full_q  <= 1'b1;
							state_q <= S_DONE;
						end
					end
				end
				S_CHECK: begin
					if (fits) begin
						state_q <= S_DONE;
					end else begin
						cur_plate_q   <= nxt_plate;
						cur_surface_q <= nxt_surface;
						cur_track_q   <= nxt_track;
						cur_sector_q  <= nxt_sector;
						if (run_out) begin
							full_q  <= 1'b1;
							state_q <= S_DONE;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// pending result and request length
	ssa_pkg::rsp_t res_d;

	always_comb begin
		res_d = res_q;
		if (req_take) begin
			res_d = '0;
			if (req.command == ssa_pkg::CMD_REWIND) begin
				res_d.status = ssa_pkg::ST_REWOUND;
			end else if (req.length > cap) begin
				res_d.status = ssa_pkg::ST_TOO_LARGE;
			end else if (full_q) begin
				res_d.status = ssa_pkg::ST_FULL;
			end
		end else if ((state_q == S_READ && !in_geom && run_out) ||
		             (state_q == S_CHECK && !fits && run_out)) begin
			res_d        = '0;
			res_d.status = ssa_pkg::ST_FULL;
		end else if (state_q == S_CHECK && fits) begin
			res_d.status       = ssa_pkg::ST_PLACED;
			res_d.plate        = cur_plate_q;
			res_d.surface      = cur_surface_q;
			res_d.track        = cur_track_q;
			res_d.sector_index = cur_sector_q;
			res_d.byte_offset  = used[ssa_pkg::OFFS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			len_q <= req.length;
		end
		res_q <= res_d;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && rsp_free) begin
			rsp_q <= res_q;
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== hdl/ssa_checker.sv =====
// port-level checks for the sector allocator, bound to the allocator core
module ssa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_stall,
	input logic                          rsp_valid,
	input logic                          rsp_stall,
	input ssa_pkg::rsp_t                 rsp
);

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result beat changed");

	// only a placed record carries an address
	a_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ssa_pkg::ST_PLACED |->
		rsp.plate == '0 && rsp.surface == '0 && rsp.track == '0 &&
		rsp.sector_index == '0 && rsp.byte_offset == '0)
		else $error("address fields set on a result that was not placed");

	// one request at a time: busy right after a request beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while a request was in progress");

	// a new result only comes from a request in progress
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result appeared with no request in progress");

endmodule

bind sequential_sector_allocator_core ssa_checker u_ssa_checker (.*);
